[rtl/core/escu_pkg.sv]
// Shared types, codes and constants for the encoder speed and count unit.
`default_nettype none
package escu_pkg;

    localparam int unsigned NUM_W = 41;
    localparam int unsigned DEN_W = 64;
    localparam int unsigned REM_W = NUM_W + 1;
    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    localparam logic [1:0] KIND_PULSE = 2'd0;
    localparam logic [1:0] KIND_SPEED = 2'd1;
    localparam logic [1:0] KIND_COUNT = 2'd2;

    localparam logic REG_PPR  = 1'b0;
    localparam logic REG_GEAR = 1'b1;

    localparam logic RK_SPEED = 1'b0;
    localparam logic RK_COUNT = 1'b1;

    localparam logic [15:0] PPR_RESET  = 16'd1;
    localparam logic [15:0] GEAR_RESET = 16'd10;

    localparam logic [29:0] SPEED_NUM   = 30'd600000000;
    localparam logic [9:0]  COUNT_SCALE = 10'd1000;

    localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_FIX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

[rtl/core/encoder_speed_and_count_unit.sv]
// Top level of the encoder speed and count unit: state, sequencer and stream ports.
// A pulse beat is absorbed without leaving the rest state and gives no result; a stale
// speed read returns 0 through the done state and the output register. A fresh speed
// read or a count read passes two multiply steps that form the divisor, a divider
// start, the shared one-bit-per-cycle divider, a finish step, a sign and saturation
// step and the output load. The input is not ready while an item is at work; the
// result waits in an output register, so the next item is taken as soon as the
// sequencer is back at rest. Speed is 600000000 / (period * ppr * gear tenths) in
// signed rpm, count is signed hundredths of revolutions and is cleared when read.
`default_nettype none
module encoder_speed_and_count_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] now_us, [32] direction_level, rest zero
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] reading
    output logic             m_tuser,   // [0] reading_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    escu_pkg::state_t state_reg;
    escu_pkg::state_t state_next;

    logic [15:0] ppr_reg;
    logic [15:0] ppr_next;
    logic [15:0] gear_reg;
    logic [15:0] gear_next;
    logic [31:0] last_reg;
    logic [31:0] last_next;
    logic [31:0] period_reg;
    logic [31:0] period_next;
    logic        ccw_reg;
    logic        ccw_next;
    logic        stale_reg;
    logic        stale_next;
    logic [31:0] count_reg;
    logic [31:0] count_next;

    logic        is_count_reg;
    logic        is_count_next;
    logic        neg_reg;
    logic        neg_next;
    logic [31:0] p_reg;
    logic [31:0] p_next;
    logic [47:0] prod_reg;
    logic [47:0] prod_next;
    logic [escu_pkg::DEN_W-1:0] den_reg;
    logic [escu_pkg::DEN_W-1:0] den_next;
    logic [escu_pkg::NUM_W-1:0] num_reg;
    logic [escu_pkg::NUM_W-1:0] num_next;
    logic [31:0] res_reg;
    logic [31:0] res_next;
    logic        rk_reg;
    logic        rk_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_data_reg;
    logic [31:0] out_data_next;
    logic        out_kind_reg;
    logic        out_kind_next;

    logic        div_start;
    logic        div_start_seen_reg;
    escu_pkg::div_stat_t        div_stat;
    logic [escu_pkg::NUM_W-1:0] div_quo;

    logic        in_fire;
    logic [31:0] now_us;
    logic        dir_level;
    logic [31:0] age;
    logic [47:0] mul_pp;
    logic [31:0] mul_pg;
    logic [41:0] mul_scaled;
    logic [63:0] mul_den;
    logic [29:0] speed_q;
    logic        den_zero;

    assign in_fire   = s_tvalid && s_tready;
    assign now_us    = s_tdata[31:0];
    assign dir_level = s_tdata[32];
    assign age       = now_us - last_reg;

    assign mul_pp     = {16'd0, p_reg} * {32'd0, ppr_reg};
    assign mul_pg     = {16'd0, ppr_reg} * {16'd0, gear_reg};
    assign mul_scaled = {10'd0, p_reg} * {32'd0, escu_pkg::COUNT_SCALE};
    assign mul_den    = {16'd0, prod_reg} * {48'd0, gear_reg};

    assign den_zero = (den_reg == '0);
    assign speed_q  = den_zero ? escu_pkg::SPEED_NUM : div_quo[29:0];

    escu_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        ppr_next       = ppr_reg;
        gear_next      = gear_reg;
        last_next      = last_reg;
        period_next    = period_reg;
        ccw_next       = ccw_reg;
        stale_next     = stale_reg;
        count_next     = count_reg;
        is_count_next  = is_count_reg;
        neg_next       = neg_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        res_next       = res_reg;
        rk_next        = rk_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        div_start      = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                escu_pkg::REG_PPR:  ppr_next  = cfg_data;
                escu_pkg::REG_GEAR: gear_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            escu_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_tuser)
                        escu_pkg::KIND_PULSE:
                        begin
                            period_next = age;
                            last_next   = now_us;
                            ccw_next    = dir_level;
                            count_next  = dir_level ? count_reg - 32'd1 : count_reg + 32'd1;
                            stale_next  = 1'b0;
                        end
                        escu_pkg::KIND_SPEED:
                        begin
                            rk_next = escu_pkg::RK_SPEED;
                            if (stale_reg)
                            begin
                                res_next   = '0;
                                state_next = escu_pkg::ST_DONE;
                            end
                            else
                            begin
                                is_count_next = 1'b0;
                                neg_next      = ccw_reg;
                                num_next      = escu_pkg::NUM_W'(escu_pkg::SPEED_NUM);
                                if (age >= period_reg)
                                begin
                                    p_next     = age;
                                    stale_next = 1'b1;
                                end
                                else
                                begin
                                    p_next = period_reg;
                                end
                                state_next = escu_pkg::ST_MUL1;
                            end
                        end
                        escu_pkg::KIND_COUNT:
                        begin
                            rk_next       = escu_pkg::RK_COUNT;
                            is_count_next = 1'b1;
                            neg_next      = count_reg[31];
                            p_next        = count_reg[31] ? 32'd0 - count_reg : count_reg;
                            count_next    = '0;
                            state_next    = escu_pkg::ST_MUL1;
                        end
                        default: ;
                    endcase
                end
            end
            escu_pkg::ST_MUL1:
            begin
                if (is_count_reg)
                begin
                    prod_next = {16'd0, mul_pg};
                    num_next  = mul_scaled[escu_pkg::NUM_W-1:0];
                end
                else
                begin
                    prod_next = mul_pp;
                end
                state_next = escu_pkg::ST_MUL2;
            end
            escu_pkg::ST_MUL2:
            begin
                den_next   = is_count_reg ? {16'd0, prod_reg} : mul_den;
                state_next = escu_pkg::ST_DIV;
            end
            escu_pkg::ST_DIV:
            begin
                div_start = !div_stat.busy && !div_stat.done && !div_start_seen_reg;
                if (div_stat.done)
                begin
                    state_next = escu_pkg::ST_FIX;
                end
            end
            escu_pkg::ST_FIX:
            begin
                if (!is_count_reg)
                begin
                    res_next = neg_reg ? 32'd0 - {2'd0, speed_q} : {2'd0, speed_q};
                end
                else if (den_zero)
                begin
                    if (p_reg == '0)
                    begin
                        res_next = '0;
                    end
                    else
                    begin
                        res_next = neg_reg ? escu_pkg::S32_MIN : escu_pkg::S32_MAX;
                    end
                end
                else if (neg_reg)
                begin
                    res_next = (div_quo > escu_pkg::NUM_W'(escu_pkg::S32_MIN)) ?
                               escu_pkg::S32_MIN : 32'd0 - div_quo[31:0];
                end
                else
                begin
                    res_next = (div_quo > escu_pkg::NUM_W'(escu_pkg::S32_MAX)) ?
                               escu_pkg::S32_MAX : div_quo[31:0];
                end
                state_next = escu_pkg::ST_DONE;
            end
            escu_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    out_kind_next  = rk_reg;
                    state_next     = escu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = escu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_start_seen_reg <= 1'b0;
        end
        else
        begin
            div_start_seen_reg <= (state_reg == escu_pkg::ST_DIV);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= escu_pkg::ST_IDLE;
            ppr_reg       <= escu_pkg::PPR_RESET;
            gear_reg      <= escu_pkg::GEAR_RESET;
            last_reg      <= '0;
            period_reg    <= '0;
            ccw_reg       <= 1'b0;
            stale_reg     <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ppr_reg       <= ppr_next;
            gear_reg      <= gear_next;
            last_reg      <= last_next;
            period_reg    <= period_next;
            ccw_reg       <= ccw_next;
            stale_reg     <= stale_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_count_reg <= is_count_next;
        neg_reg      <= neg_next;
        p_reg        <= p_next;
        prod_reg     <= prod_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        res_reg      <= res_next;
        rk_reg       <= rk_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
    end

    assign s_tready  = (state_reg == escu_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_kind_reg;

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == escu_pkg::ST_IDLE) |-> !div_stat.busy)
        else $error("divider busy while sequencer at rest");

    a_pulse_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser == escu_pkg::KIND_PULSE) |=> !stale_reg)
        else $error("pulse beat left data stale");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser == escu_pkg::KIND_COUNT) |=> (count_reg == '0))
        else $error("count read did not clear the count");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == escu_pkg::ST_DIV))
        else $error("divider finished outside the divide step");

endmodule
`default_nettype wire

[rtl/core/escu_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module escu_div
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [escu_pkg::NUM_W-1:0]        num,
    input  wire logic [escu_pkg::DEN_W-1:0]        den,
    output escu_pkg::div_stat_t                    stat,
    output logic      [escu_pkg::NUM_W-1:0]        quo
);

    logic [escu_pkg::NUM_W-1:0] quo_reg;
    logic [escu_pkg::NUM_W-1:0] quo_next;
    logic [escu_pkg::NUM_W-1:0] rem_reg;
    logic [escu_pkg::NUM_W-1:0] rem_next;
    logic [escu_pkg::REM_W-1:0] dsr_reg;
    logic [escu_pkg::REM_W-1:0] dsr_next;
    logic                       big_reg;
    logic                       big_next;
    logic [escu_pkg::CNT_W-1:0] cnt_reg;
    logic [escu_pkg::CNT_W-1:0] cnt_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;

    logic [escu_pkg::REM_W-1:0] trial;
    logic [escu_pkg::REM_W-1:0] diff;
    logic                       ge;

    assign trial = {rem_reg, quo_reg[escu_pkg::NUM_W-1]};
    assign diff  = trial - dsr_reg;
    assign ge    = !big_reg && (trial >= dsr_reg);

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        big_next  = big_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            dsr_next  = den[escu_pkg::REM_W-1:0];
            big_next  = |den[escu_pkg::DEN_W-1:escu_pkg::REM_W];
            cnt_next  = escu_pkg::CNT_W'(escu_pkg::NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[escu_pkg::NUM_W-2:0], ge};
            rem_next = ge ? diff[escu_pkg::NUM_W-1:0] : trial[escu_pkg::NUM_W-1:0];
            cnt_next = cnt_reg - escu_pkg::CNT_W'(1);
            if (cnt_reg == escu_pkg::CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        big_reg <= big_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule
`default_nettype wire
